// ===== rtl/crs_pkg.sv =====
// crs_pkg: shared types, codes and arithmetic helpers of the catmull-rom spline evaluator
// no dependencies; used by crs_ctrl, crs_dp and the top level

package crs_pkg;

    // accumulator width: bounds the horner sums of 32-bit coordinates
    localparam int ACC_W = 37;

    typedef logic signed [ACC_W-1:0] acc_t;

    // item command codes
    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // coefficient selects
    localparam logic [1:0] COEF_C0 = 2'd0;
    localparam logic [1:0] COEF_C1 = 2'd1;
    localparam logic [1:0] COEF_C2 = 2'd2;
    localparam logic [1:0] COEF_C3 = 2'd3;

    localparam acc_t ACC_MAX = acc_t'(32'sh7fff_ffff);
    localparam acc_t ACC_MIN = acc_t'(32'sh8000_0000);

    typedef struct packed {
        logic       clr_en;
        logic       load_in;
        logic       wr_en;
        logic       seg_mul;
        logic       seg_fix;
        logic       rd_en;
        logic [1:0] rd_k;
        logic       cap_en;
        logic [1:0] cap_k;
        logic       init_acc;
        logic       mul_en;
        logic [1:0] mul_ax;
        logic       upd_en;
        logic [1:0] upd_ax;
        logic [1:0] upd_sel;
        logic       out_load;
    } crs_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       out_free;
    } crs_sts_t;

    // uniform catmull-rom coefficient times two, exact integer
    function automatic acc_t coef(input logic signed [31:0] p0, input logic signed [31:0] p1,
                                  input logic signed [31:0] p2, input logic signed [31:0] p3,
                                  input logic [1:0] sel);
        acc_t e0, e1, e2, e3, r;
        e0 = acc_t'(p0);
        e1 = acc_t'(p1);
        e2 = acc_t'(p2);
        e3 = acc_t'(p3);
        unique case (sel)
            COEF_C0: r = e1 <<< 1;
            COEF_C1: r = e2 - e0;
            COEF_C2: r = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
            default: r = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
        endcase
        return r;
    endfunction

    // floor((a+1)/2) saturated to 32 bits
    function automatic logic [31:0] half_sat(input acc_t a);
        acc_t h;
        h = (a + acc_t'(1)) >>> 1;
        if (h > ACC_MAX) h = ACC_MAX;
        else if (h < ACC_MIN) h = ACC_MIN;
        return h[31:0];
    endfunction

endpackage

// ===== rtl/crs_ram.sv =====
// crs_ram: generic single-write, single-read ram with registered read
// no dependencies

module crs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/crs_ctrl.sv =====
// crs_ctrl: sequencer of the spline evaluator (clear pass, writes, segment, reads, horner)
// depends on crs_pkg

module crs_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [1:0]      s_cmd,
    output logic            s_ready,
    input  crs_pkg::crs_sts_t sts,
    output crs_pkg::crs_cmd_t cmd
);
    import crs_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_WR   = 4'd2;
    localparam logic [3:0] S_SEG  = 4'd3;
    localparam logic [3:0] S_FIX  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_INIT = 4'd6;
    localparam logic [3:0] S_HORN = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [1:0] ax_reg, ax_next;
    logic [1:0] st_reg, st_next;
    logic       pend_reg, pend_next;
    logic [1:0] pax_reg, pax_next;
    logic [1:0] pst_reg, pst_next;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        ax_next    = ax_reg;
        st_next    = st_reg;
        pend_next  = 1'b0;
        pax_next   = ax_reg;
        pst_next   = st_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    if (s_cmd == CMD_SET || s_cmd == CMD_APPEND) state_next = S_WR;
                    else if (s_cmd == CMD_EVAL) state_next = S_SEG;
                end
            end
            S_WR: begin
                cmd.wr_en  = 1'b1;
                state_next = S_IDLE;
            end
            S_SEG: begin
                cmd.seg_mul = 1'b1;
                state_next  = S_FIX;
            end
            S_FIX: begin
                cmd.seg_fix = 1'b1;
                k_next      = 3'd0;
                state_next  = S_RD;
            end
            S_RD: begin
                cmd.rd_en  = ~k_reg[2];
                cmd.rd_k   = k_reg[1:0];
                cmd.cap_en = (k_reg != 3'd0);
                cmd.cap_k  = 2'(k_reg - 3'd1);
                k_next     = k_reg + 3'd1;
                if (k_reg[2]) state_next = S_INIT;
            end
            S_INIT: begin
                cmd.init_acc = 1'b1;
                ax_next      = 2'd0;
                st_next      = 2'd0;
                state_next   = S_HORN;
            end
            S_HORN: begin
                // one product per cycle, round-robin over axes; its sum lands in the following cycle
                cmd.mul_en  = (st_reg != 2'd3);
                cmd.mul_ax  = ax_reg;
                cmd.upd_en  = pend_reg;
                cmd.upd_ax  = pax_reg;
                unique case (pst_reg)
                    2'd0:    cmd.upd_sel = COEF_C2;
                    2'd1:    cmd.upd_sel = COEF_C1;
                    default: cmd.upd_sel = COEF_C0;
                endcase
                pend_next = cmd.mul_en;
                if (cmd.mul_en) begin
                    if (ax_reg == 2'd2) begin
                        ax_next = 2'd0;
                        st_next = st_reg + 2'd1;
                    end else begin
                        ax_next = ax_reg + 2'd1;
                    end
                end else if (!pend_reg) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            k_reg     <= '0;
            ax_reg    <= '0;
            st_reg    <= '0;
            pend_reg  <= 1'b0;
            pax_reg   <= '0;
            pst_reg   <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            ax_reg    <= ax_next;
            st_reg    <= st_next;
            pend_reg  <= pend_next;
            pax_reg   <= pax_next;
            pst_reg   <= pst_next;
        end
    end

endmodule

// ===== rtl/crs_dp.sv =====
// crs_dp: datapath of the spline evaluator: point table, shared multiplier, accumulators
// depends on crs_pkg and crs_ram

module crs_dp #(
    parameter int MAX_POINTS = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [8:0]        cfg_data,
    input  logic [1:0]        s_cmd,
    input  logic [7:0]        s_point_index,
    input  logic [31:0]       s_point_x,
    input  logic [31:0]       s_point_y,
    input  logic [31:0]       s_point_z,
    input  logic [17:0]       s_position,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_curve_x,
    output logic [31:0]       m_curve_y,
    output logic [31:0]       m_curve_z,
    input  crs_pkg::crs_cmd_t cmd,
    output crs_pkg::crs_sts_t sts
);
    import crs_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int P_W    = FRAC_BITS + 1;
    localparam int MB_W   = FRAC_BITS + 2;
    localparam int PROD_W = ACC_W + MB_W;
    localparam int ONE    = 1 << FRAC_BITS;
    localparam int HALF   = 1 << (FRAC_BITS - 1);

    logic [8:0]              count_reg;
    logic [CNT_W-1:0]        cnt, cntm3;
    logic [1:0]              cmd_reg;
    logic [7:0]              idx_reg;
    logic [95:0]             pt_reg;
    logic signed [17:0]      pos_reg;
    logic [CNT_W-1:0]        slot_reg;
    logic [IDX_W-1:0]        clr_reg;
    logic [CNT_W-1:0]        seg_reg;
    logic [P_W-1:0]          t_reg;
    logic [P_W-1:0]          p_clamp;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic [95:0]             pts_reg [4];
    acc_t                    acc_reg [3];
    acc_t                    coefs [3][4];
    logic                    set_ok, app_ok;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr, ram_raddr;
    logic [95:0]             ram_wdata, ram_rdata;
    logic [CNT_W-1:0]        seg_raw;
    logic signed [PROD_W-1:0] rnd_full;
    acc_t                    upd_val;
    logic                    m_valid_reg;
    logic [31:0]             mx_reg, my_reg, mz_reg;

    // effective point count clamped to 4..MAX_POINTS
    always_comb begin
        if (count_reg < 9'd4) cnt = CNT_W'(4);
        else if (int'(count_reg) > MAX_POINTS) cnt = CNT_W'(MAX_POINTS);
        else cnt = CNT_W'(count_reg);
    end
    assign cntm3 = cnt - CNT_W'(3);

    always_comb begin
        if (pos_reg[17]) p_clamp = '0;
        else if (int'(pos_reg) > ONE) p_clamp = P_W'(ONE);
        else p_clamp = P_W'(pos_reg);
    end

    assign set_ok = (cmd_reg == CMD_SET) && (int'(idx_reg) < int'(cnt));
    assign app_ok = (cmd_reg == CMD_APPEND) && (slot_reg < cnt);

    assign ram_we    = cmd.clr_en || (cmd.wr_en && (set_ok || app_ok));
    assign ram_waddr = cmd.clr_en ? clr_reg
                     : ((cmd_reg == CMD_SET) ? IDX_W'(idx_reg) : IDX_W'(slot_reg));
    assign ram_wdata = cmd.clr_en ? '0 : pt_reg;
    assign ram_raddr = IDX_W'(seg_reg + CNT_W'(cmd.rd_k));

    crs_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // coefficients for each axis from the four captured points
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 4; c++) begin
                coefs[a][c] = coef(pts_reg[0][95-32*a -: 32], pts_reg[1][95-32*a -: 32],
                                   pts_reg[2][95-32*a -: 32], pts_reg[3][95-32*a -: 32],
                                   2'(c));
            end
        end
    end

    assign mul_a = cmd.seg_mul ? ACC_W'(cntm3) : acc_reg[cmd.mul_ax];
    assign mul_b = cmd.seg_mul ? MB_W'(p_clamp) : MB_W'(t_reg);

    assign seg_raw  = prod_reg[FRAC_BITS +: CNT_W];
    assign rnd_full = (prod_reg + PROD_W'(HALF)) >>> FRAC_BITS;
    assign upd_val  = $signed(rnd_full[ACC_W-1:0]) + coefs[cmd.upd_ax][cmd.upd_sel];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= 9'd4;
            slot_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) count_reg <= cfg_data;
            if (cmd.clr_en) clr_reg <= clr_reg + IDX_W'(1);
            if (cmd.wr_en && app_ok) slot_reg <= slot_reg + CNT_W'(1);
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg <= s_cmd;
            idx_reg <= s_point_index;
            pt_reg  <= {s_point_x, s_point_y, s_point_z};
            pos_reg <= s_position;
        end
        if (cmd.seg_mul || cmd.mul_en) begin
            prod_reg <= PROD_W'(mul_a * mul_b);
        end
        if (cmd.seg_fix) begin
            if (seg_raw >= cntm3) begin
                seg_reg <= cnt - CNT_W'(4);
                t_reg   <= P_W'(ONE);
            end else begin
                seg_reg <= seg_raw;
                t_reg   <= {1'b0, prod_reg[FRAC_BITS-1:0]};
            end
        end
        if (cmd.cap_en) pts_reg[cmd.cap_k] <= ram_rdata;
        if (cmd.init_acc) begin
            for (int a = 0; a < 3; a++) acc_reg[a] <= coefs[a][COEF_C3];
        end else if (cmd.upd_en) begin
            acc_reg[cmd.upd_ax] <= upd_val;
        end
        if (cmd.out_load) begin
            mx_reg <= half_sat(acc_reg[0]);
            my_reg <= half_sat(acc_reg[1]);
            mz_reg <= half_sat(acc_reg[2]);
        end
    end

    assign sts.clr_last = (clr_reg == IDX_W'(MAX_POINTS - 1));
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid   = m_valid_reg;
    assign m_curve_x = mx_reg;
    assign m_curve_y = my_reg;
    assign m_curve_z = mz_reg;

endmodule

// ===== rtl/catmull_rom_spline_eval_top.sv =====
// catmull_rom_spline_eval_top: top level of the uniform catmull-rom spline evaluator
// depends on crs_pkg, crs_ctrl, crs_dp (which holds crs_ram)

// The block keeps a table of up to MAX_POINTS 3D control points (signed Q16.16) and
// evaluates the uniform catmull-rom curve through them. Each input word is a set (write
// the point at point_index), an append (write at the next append slot) or an evaluate
// (position in Q1.FRAC_BITS, clamped to 0..1, mapped over segments 1..count-2); writes at
// or beyond the active count are dropped, command code 3 is ignored. Only an evaluate
// produces a result word: x, y and z rounded and saturated to 32 bits. After reset the
// block zeroes every entry of the point table, with s_ready low. A set or append then
// is a single table write; an evaluate runs from acceptance to the result
// register: one product for the segment split, four reads through the table's single read
// port and nine horner products through the one shared multiplier. A finished result waits
// in the output register while the next word is accepted. point_count is written through
// the cfg port at any time the block is idle; cfg_ready is always high.

module catmull_rom_spline_eval_top #(
    parameter int MAX_POINTS = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // point_count register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_point_index,
    input  logic [31:0] s_point_x,
    input  logic [31:0] s_point_y,
    input  logic [31:0] s_point_z,
    input  logic [17:0] s_position,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_curve_x,
    output logic [31:0] m_curve_y,
    output logic [31:0] m_curve_z
);
    import crs_pkg::*;

    crs_cmd_t ctl_cmd;
    crs_sts_t dp_sts;

    assign cfg_ready = 1'b1;

    // sequencer: owns all timing, drives one command bundle per cycle
    crs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .sts     (dp_sts),
        .cmd     (ctl_cmd)
    );

    // table, multiplier, accumulators and output register
    crs_dp #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .s_cmd         (s_cmd),
        .s_point_index (s_point_index),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_point_z     (s_point_z),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_curve_x     (m_curve_x),
        .m_curve_y     (m_curve_y),
        .m_curve_z     (m_curve_z),
        .cmd           (ctl_cmd),
        .sts           (dp_sts)
    );

    // the table clear pass always follows reset, so no word is taken right after it
    a_clear_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !s_ready)
        else $error("input accepted during table clear");

    // a result is never loaded over one still waiting
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register overwritten");

    // the product being summed never belongs to the axis being multiplied
    a_axis_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_cmd.mul_en && ctl_cmd.upd_en) |-> (ctl_cmd.mul_ax != ctl_cmd.upd_ax))
        else $error("horner axis collision");

    // accepted words are only taken while the datapath is quiet
    a_idle_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !(ctl_cmd.mul_en || ctl_cmd.upd_en || ctl_cmd.rd_en))
        else $error("input accepted while busy");

endmodule
